@@ rtl/grl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the grammar rule lexer.
// Used by grl_front, grl_queue, grl_back and grammar_rule_lexer; no dependencies.
package grl_pkg;

  // Most token events one source character can release
  localparam int MAX_EV     = 6;
  localparam int EV_CNT_W   = $clog2(MAX_EV + 1);
  localparam int EV_IDX_W   = $clog2(MAX_EV);

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Token kinds
  localparam logic [3:0] K_OPEN        = 4'd0;
  localparam logic [3:0] K_CLOSE       = 4'd1;
  localparam logic [3:0] K_AND         = 4'd2;
  localparam logic [3:0] K_OR          = 4'd3;
  localparam logic [3:0] K_DEFINE      = 4'd4;
  localparam logic [3:0] K_DEFINE_END  = 4'd5;
  localparam logic [3:0] K_IDENT_CHAR  = 4'd6;
  localparam logic [3:0] K_IDENT_END   = 4'd7;
  localparam logic [3:0] K_LIT_CHAR    = 4'd8;
  localparam logic [3:0] K_LIT_END     = 4'd9;
  localparam logic [3:0] K_ERR_LIT     = 4'd10;
  localparam logic [3:0] K_ERR_COMMENT = 4'd11;
  localparam logic [3:0] K_SOURCE_END  = 4'd12;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_LIT     = 3'd2,
    MODE_LIT_ESC = 3'd3,
    MODE_LINE    = 3'd4,
    MODE_BLOCK   = 3'd5
  } scan_mode_t;

  // Events released by one source character
  typedef struct packed {
    logic [EV_CNT_W-1:0]        cnt;
    logic [MAX_EV-1:0][3:0]     kind;
    logic [MAX_EV-1:0][7:0]     chr;
  } bundle_t;

endpackage

@@ rtl/grammar_rule_lexer.sv @@
`timescale 1ns / 1ps
// Grammar rule lexer: one source character in per item, token events out,
// one per item. Built from grl_front, grl_queue and grl_back; uses grl_pkg.
//
// Send the source one character per item on the in_ channel with in_tlast on
// its final character. Each character releases zero to six token events on
// the out_ channel (kind in out_tuser, character in out_tdata, out_tlast on the
// last event a character caused); characters that only extend a comment,
// whitespace or a held mark release none. The front end decodes a character
// in the cycle it is taken and can take one every cycle while the four-deep
// bundle queue has room; the back end sends one event per cycle while the
// receiver holds out_tready high. A character's first event passes through
// the bundle queue and then the output register, at the earliest, before
// out_tvalid offers it. Error events (unterminated literal or block
// comment) come just before source_end; discarding the tokens of such a source
// is up to the user.
module grammar_rule_lexer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_char
  input  logic       in_tlast,   // end_of_source
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] token_char
  output logic [3:0] out_tuser,  // [3:0] token_kind
  output logic       out_tlast   // last_of_item
);

  logic             q_push;
  logic             q_can_push;
  logic             q_pop;
  logic             q_head_valid;
  grl_pkg::bundle_t q_push_data;
  grl_pkg::bundle_t q_head;

  grl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_can_push (q_can_push),
    .q_push     (q_push),
    .q_data     (q_push_data)
  );

  grl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .can_push   (q_can_push),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  grl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/grl_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts source characters, tracks the scan state and builds
// the event bundle each character releases. Depends on grl_pkg.
module grl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] text_char
  input  logic              in_tlast,   // end_of_source
  input  logic              q_can_push,
  output logic              q_push,
  output grl_pkg::bundle_t  q_data
);

  typedef struct packed {
    grl_pkg::scan_mode_t mode;
    logic [7:0]          held_c;
    logic                held_v;
    logic                aft;
    grl_pkg::bundle_t    ev;
  } lex_t;

  grl_pkg::scan_mode_t mode_r, mode_nxt;
  logic [7:0]          held_c_r, held_c_nxt;
  logic                held_v_r, held_v_nxt;
  logic                aft_r, aft_nxt;
  logic                accept;
  lex_t                cur;
  lex_t                step;

  function automatic lex_t f_emit(lex_t s, logic [3:0] k, logic [7:0] c);
    lex_t r;
    r = s;
    if (r.ev.cnt < grl_pkg::EV_CNT_W'(grl_pkg::MAX_EV)) begin
      r.ev.kind[r.ev.cnt] = k;
      r.ev.chr[r.ev.cnt]  = c;
      r.ev.cnt = r.ev.cnt + grl_pkg::EV_CNT_W'(1);
    end
    return r;
  endfunction

  function automatic lex_t f_close(lex_t s);
    lex_t r;
    r = s;
    if (r.mode == grl_pkg::MODE_IDENT) begin
      r = f_emit(r, grl_pkg::K_IDENT_END, grl_pkg::CH_NUL);
      r.aft = 1'b1;
    end
    r.mode = grl_pkg::MODE_IDLE;
    return r;
  endfunction

  function automatic lex_t f_put_ident(lex_t s, logic [7:0] c);
    lex_t r;
    r = s;
    if (r.mode != grl_pkg::MODE_IDENT) begin
      if (r.aft) begin
        r = f_emit(r, grl_pkg::K_AND, grl_pkg::CH_NUL);
      end
      r.mode = grl_pkg::MODE_IDENT;
    end
    r = f_emit(r, grl_pkg::K_IDENT_CHAR, c);
    return r;
  endfunction

  // Character between tokens or inside an identifier, nothing held
  function automatic lex_t f_plain(lex_t s, logic [7:0] c);
    lex_t r;
    r = s;
    unique case (c) inside
      grl_pkg::CH_SPACE, grl_pkg::CH_NL: begin
        r = f_close(r);
      end
      grl_pkg::CH_OPEN: begin
        r = f_close(r);
        if (r.aft) begin
          r = f_emit(r, grl_pkg::K_AND, grl_pkg::CH_NUL);
        end
        r = f_emit(r, grl_pkg::K_OPEN, grl_pkg::CH_NUL);
        r.aft = 1'b0;
      end
      grl_pkg::CH_CLOSE: begin
        r = f_close(r);
        r = f_emit(r, grl_pkg::K_CLOSE, grl_pkg::CH_NUL);
        r.aft = 1'b1;
      end
      grl_pkg::CH_AMP: begin
        r = f_close(r);
        r = f_emit(r, grl_pkg::K_AND, grl_pkg::CH_NUL);
        r.aft = 1'b0;
      end
      grl_pkg::CH_BAR: begin
        r = f_close(r);
        r = f_emit(r, grl_pkg::K_OR, grl_pkg::CH_NUL);
        r.aft = 1'b0;
      end
      grl_pkg::CH_SEMI: begin
        r = f_close(r);
        r = f_emit(r, grl_pkg::K_DEFINE_END, grl_pkg::CH_NUL);
        r.aft = 1'b0;
      end
      grl_pkg::CH_QUOTE: begin
        r = f_close(r);
        if (r.aft) begin
          r = f_emit(r, grl_pkg::K_AND, grl_pkg::CH_NUL);
        end
        r.mode = grl_pkg::MODE_LIT;
      end
      grl_pkg::CH_MINUS, grl_pkg::CH_SLASH, grl_pkg::CH_STAR: begin
        r.held_c = c;
        r.held_v = 1'b1;
      end
      default: begin
        r = f_put_ident(r, c);
      end
    endcase
    return r;
  endfunction

  // Resolve a held mark against its successor
  function automatic lex_t f_token(lex_t s, logic [7:0] c);
    lex_t       r;
    logic [7:0] h;
    r = s;
    h = r.held_c;
    if (!r.held_v) begin
      r = f_plain(r, c);
    end else begin
      r.held_v = 1'b0;
      r.held_c = grl_pkg::CH_NUL;
      if (h == grl_pkg::CH_MINUS && c == grl_pkg::CH_GT) begin
        r = f_close(r);
        r = f_emit(r, grl_pkg::K_DEFINE, grl_pkg::CH_NUL);
        r.aft = 1'b0;
      end else if (h == grl_pkg::CH_SLASH && c == grl_pkg::CH_SLASH) begin
        r = f_close(r);
        r.mode = grl_pkg::MODE_LINE;
      end else if (h == grl_pkg::CH_SLASH && c == grl_pkg::CH_STAR) begin
        r = f_close(r);
        r.mode = grl_pkg::MODE_BLOCK;
      end else if (h == grl_pkg::CH_STAR && c == grl_pkg::CH_SLASH) begin
        // stray block-comment close: drop it
        r = f_close(r);
      end else begin
        r = f_put_ident(r, h);
        r = f_plain(r, c);
      end
    end
    return r;
  endfunction

  function automatic lex_t f_step(lex_t s, logic [7:0] c, logic last);
    lex_t r;
    r = s;
    r.ev = '0;
    unique case (r.mode)
      grl_pkg::MODE_LIT: begin
        if (c == grl_pkg::CH_BSLASH) begin
          r = f_emit(r, grl_pkg::K_LIT_CHAR, c);
          r.mode = grl_pkg::MODE_LIT_ESC;
        end else if (c == grl_pkg::CH_QUOTE) begin
          r = f_emit(r, grl_pkg::K_LIT_END, grl_pkg::CH_NUL);
          r.aft  = 1'b1;
          r.mode = grl_pkg::MODE_IDLE;
        end else begin
          r = f_emit(r, grl_pkg::K_LIT_CHAR, c);
        end
      end
      grl_pkg::MODE_LIT_ESC: begin
        r = f_emit(r, grl_pkg::K_LIT_CHAR, c);
        r.mode = grl_pkg::MODE_LIT;
      end
      grl_pkg::MODE_LINE: begin
        if (c == grl_pkg::CH_NL) begin
          r.mode = grl_pkg::MODE_IDLE;
        end
      end
      grl_pkg::MODE_BLOCK: begin
        if (r.held_v && c == grl_pkg::CH_SLASH) begin
          r.held_v = 1'b0;
          r.held_c = grl_pkg::CH_NUL;
          r.mode   = grl_pkg::MODE_IDLE;
        end else begin
          r.held_v = (c == grl_pkg::CH_STAR);
          r.held_c = r.held_v ? c : grl_pkg::CH_NUL;
        end
      end
      grl_pkg::MODE_IDENT: begin
        r = f_token(r, c);
      end
      default: begin
        r.mode = grl_pkg::MODE_IDLE;
        r = f_token(r, c);
      end
    endcase

    if (last) begin
      if (r.mode == grl_pkg::MODE_IDLE || r.mode == grl_pkg::MODE_IDENT) begin
        if (r.held_v) begin
          r = f_put_ident(r, r.held_c);
        end
        r = f_close(r);
      end else if (r.mode == grl_pkg::MODE_LIT || r.mode == grl_pkg::MODE_LIT_ESC) begin
        r = f_emit(r, grl_pkg::K_ERR_LIT, grl_pkg::CH_NUL);
      end else if (r.mode == grl_pkg::MODE_BLOCK) begin
        r = f_emit(r, grl_pkg::K_ERR_COMMENT, grl_pkg::CH_NUL);
      end
      r = f_emit(r, grl_pkg::K_SOURCE_END, grl_pkg::CH_NUL);
      // back to reset for the next source
      r.mode   = grl_pkg::MODE_IDLE;
      r.held_c = grl_pkg::CH_NUL;
      r.held_v = 1'b0;
      r.aft    = 1'b0;
    end
    return r;
  endfunction

  assign accept = in_tvalid && q_can_push;

  always_comb begin
    cur.mode   = mode_r;
    cur.held_c = held_c_r;
    cur.held_v = held_v_r;
    cur.aft    = aft_r;
    cur.ev     = '0;
    step       = f_step(cur, in_tdata, in_tlast);
  end

  // Next state
  always_comb begin
    mode_nxt   = mode_r;
    held_c_nxt = held_c_r;
    held_v_nxt = held_v_r;
    aft_nxt    = aft_r;
    if (accept) begin
      mode_nxt   = step.mode;
      held_c_nxt = step.held_c;
      held_v_nxt = step.held_v;
      aft_nxt    = step.aft;
    end
  end

  // Outputs
  always_comb begin
    in_tready = q_can_push;
    q_push    = accept && (step.ev.cnt != '0);
    q_data    = step.ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= grl_pkg::MODE_IDLE;
      held_c_r <= grl_pkg::CH_NUL;
      held_v_r <= 1'b0;
      aft_r    <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      held_c_r <= held_c_nxt;
      held_v_r <= held_v_nxt;
      aft_r    <= aft_nxt;
    end
  end

endmodule

@@ rtl/grl_queue.sv @@
`timescale 1ns / 1ps
// Short queue of event bundles between the front and back ends.
// Depends on grl_pkg.
module grl_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  grl_pkg::bundle_t  push_data,
  output logic              can_push,
  input  logic              pop,
  output logic              head_valid,
  output grl_pkg::bundle_t  head
);

  grl_pkg::bundle_t                   slot_r [grl_pkg::QUEUE_DEPTH];
  logic [grl_pkg::QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [grl_pkg::QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [grl_pkg::QCNT_W-1:0]         cnt_r, cnt_nxt;
  logic                               do_push;
  logic                               do_pop;

  assign can_push   = (cnt_r != grl_pkg::QCNT_W'(grl_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && can_push;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + grl_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + grl_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + grl_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - grl_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/grl_back.sv @@
`timescale 1ns / 1ps
// Back end: walks the head bundle into the output register, one event per
// cycle while the receiver takes them. Depends on grl_pkg.
module grl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  grl_pkg::bundle_t  head,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] token_char
  output logic [3:0]        out_tuser,  // [3:0] token_kind
  output logic              out_tlast   // last_of_item
);

  logic [grl_pkg::EV_IDX_W-1:0] idx_r, idx_nxt;
  logic                         vld_r, vld_nxt;
  logic [3:0]                   kind_r, kind_nxt;
  logic [7:0]                   chr_r, chr_nxt;
  logic                         last_r, last_nxt;
  logic                         load;
  logic                         is_last;

  assign load    = head_valid && (!vld_r || out_tready);
  assign is_last = (grl_pkg::EV_CNT_W'(idx_r) + grl_pkg::EV_CNT_W'(1) == head.cnt);

  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r && !out_tready;
    kind_nxt = kind_r;
    chr_nxt  = chr_r;
    last_nxt = last_r;
    pop      = 1'b0;
    if (load) begin
      vld_nxt  = 1'b1;
      kind_nxt = head.kind[idx_r];
      chr_nxt  = head.chr[idx_r];
      last_nxt = is_last;
      if (is_last) begin
        // bundle drained: release it and restart at its first event
        pop     = 1'b1;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + grl_pkg::EV_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    chr_r  <= chr_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = chr_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for grammar_rule_lexer: a directed list of source
// characters, then random source texts, each token event checked in order.
// Depends on grl_pkg and the RTL; expected events: hand-typed rows or model.
module testbench;

  localparam int RANDOM_ITEMS = 480;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 24;
  // Filler for unused kind slots of a directed row
  localparam logic [3:0] K_NONE = 4'hF;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] chr;
    logic       last;
  } token_t;

  // One source character; when typed, its events are written out by hand
  typedef struct packed {
    logic [7:0]      ch;
    logic            eos;
    logic            typed;
    logic [1:0]      n;
    logic [2:0][3:0] kinds;
  } stim_row_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [3:0] out_tuser;
  logic       out_tlast;

  token_t     tokens_due[$];
  token_t     step_tokens[$];
  stim_row_t  rows[$];
  logic [7:0] src_chars[$];

  // Lexer model state
  grl_pkg::scan_mode_t lx_mode = grl_pkg::MODE_IDLE;
  logic [7:0] lx_held       = 8'h00;
  logic       lx_held_v     = 1'b0;
  logic       lx_after_opnd = 1'b0;

  int errors       = 0;
  int n_items      = 0;
  int n_sources    = 0;
  int n_tokens     = 0;
  int n_err_tokens = 0;
  int cycles       = 0;
  int rx_hold      = 0;
  bit in_steady    = 1'b0;
  bit rx_steady    = 1'b0;

  grammar_rule_lexer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic void lex_reset();
    lx_mode       = grl_pkg::MODE_IDLE;
    lx_held       = 8'h00;
    lx_held_v     = 1'b0;
    lx_after_opnd = 1'b0;
  endfunction

  function automatic void lex_emit(input logic [3:0] kind, input logic [7:0] ch);
    token_t t;
    if (step_tokens.size() < grl_pkg::MAX_EV) begin
      t.kind = kind;
      t.chr  = ch;
      t.last = 1'b0;
      step_tokens.push_back(t);
    end
  endfunction

  function automatic void lex_close_ident();
    if (lx_mode == grl_pkg::MODE_IDENT) begin
      lex_emit(grl_pkg::K_IDENT_END, grl_pkg::CH_NUL);
      lx_after_opnd = 1'b1;
    end
    lx_mode = grl_pkg::MODE_IDLE;
  endfunction

  function automatic void lex_ident_char(input logic [7:0] c);
    if (lx_mode != grl_pkg::MODE_IDENT) begin
      if (lx_after_opnd) lex_emit(grl_pkg::K_AND, grl_pkg::CH_NUL);
      lx_mode = grl_pkg::MODE_IDENT;
    end
    lex_emit(grl_pkg::K_IDENT_CHAR, c);
  endfunction

  // Character between tokens or inside an identifier, nothing held
  function automatic void lex_plain(input logic [7:0] c);
    case (c)
      grl_pkg::CH_SPACE, grl_pkg::CH_NL: lex_close_ident();
      grl_pkg::CH_OPEN: begin
        lex_close_ident();
        if (lx_after_opnd) lex_emit(grl_pkg::K_AND, grl_pkg::CH_NUL);
        lex_emit(grl_pkg::K_OPEN, grl_pkg::CH_NUL);
        lx_after_opnd = 1'b0;
      end
      grl_pkg::CH_CLOSE: begin
        lex_close_ident();
        lex_emit(grl_pkg::K_CLOSE, grl_pkg::CH_NUL);
        lx_after_opnd = 1'b1;
      end
      grl_pkg::CH_AMP: begin
        lex_close_ident();
        lex_emit(grl_pkg::K_AND, grl_pkg::CH_NUL);
        lx_after_opnd = 1'b0;
      end
      grl_pkg::CH_BAR: begin
        lex_close_ident();
        lex_emit(grl_pkg::K_OR, grl_pkg::CH_NUL);
        lx_after_opnd = 1'b0;
      end
      grl_pkg::CH_SEMI: begin
        lex_close_ident();
        lex_emit(grl_pkg::K_DEFINE_END, grl_pkg::CH_NUL);
        lx_after_opnd = 1'b0;
      end
      grl_pkg::CH_QUOTE: begin
        lex_close_ident();
        if (lx_after_opnd) lex_emit(grl_pkg::K_AND, grl_pkg::CH_NUL);
        lx_mode = grl_pkg::MODE_LIT;
      end
      grl_pkg::CH_MINUS, grl_pkg::CH_SLASH, grl_pkg::CH_STAR: begin
        lx_held   = c;
        lx_held_v = 1'b1;
      end
      default: lex_ident_char(c);
    endcase
  endfunction

  // Resolve a held mark against its successor
  function automatic void lex_mark(input logic [7:0] c);
    logic [7:0] h;
    if (!lx_held_v) begin
      lex_plain(c);
    end else begin
      h         = lx_held;
      lx_held_v = 1'b0;
      lx_held   = 8'h00;
      if (h == grl_pkg::CH_MINUS && c == grl_pkg::CH_GT) begin
        lex_close_ident();
        lex_emit(grl_pkg::K_DEFINE, grl_pkg::CH_NUL);
        lx_after_opnd = 1'b0;
      end else if (h == grl_pkg::CH_SLASH && c == grl_pkg::CH_SLASH) begin
        lex_close_ident();
        lx_mode = grl_pkg::MODE_LINE;
      end else if (h == grl_pkg::CH_SLASH && c == grl_pkg::CH_STAR) begin
        lex_close_ident();
        lx_mode = grl_pkg::MODE_BLOCK;
      end else if (h == grl_pkg::CH_STAR && c == grl_pkg::CH_SLASH) begin
        lex_close_ident();
      end else begin
        lex_ident_char(h);
        lex_plain(c);
      end
    end
  endfunction

  // Events released by one source character, left in step_tokens
  function automatic void lex_char(input logic [7:0] c, input logic eos);
    token_t t;
    step_tokens.delete();
    case (lx_mode)
      grl_pkg::MODE_LIT: begin
        if (c == grl_pkg::CH_BSLASH) begin
          lex_emit(grl_pkg::K_LIT_CHAR, c);
          lx_mode = grl_pkg::MODE_LIT_ESC;
        end else if (c == grl_pkg::CH_QUOTE) begin
          lex_emit(grl_pkg::K_LIT_END, grl_pkg::CH_NUL);
          lx_after_opnd = 1'b1;
          lx_mode = grl_pkg::MODE_IDLE;
        end else begin
          lex_emit(grl_pkg::K_LIT_CHAR, c);
        end
      end
      grl_pkg::MODE_LIT_ESC: begin
        lex_emit(grl_pkg::K_LIT_CHAR, c);
        lx_mode = grl_pkg::MODE_LIT;
      end
      grl_pkg::MODE_LINE: if (c == grl_pkg::CH_NL) lx_mode = grl_pkg::MODE_IDLE;
      grl_pkg::MODE_BLOCK: begin
        if (lx_held_v && c == grl_pkg::CH_SLASH) begin
          lx_held_v = 1'b0;
          lx_held   = 8'h00;
          lx_mode   = grl_pkg::MODE_IDLE;
        end else begin
          lx_held_v = (c == grl_pkg::CH_STAR);
          lx_held   = lx_held_v ? c : 8'h00;
        end
      end
      grl_pkg::MODE_IDENT: lex_mark(c);
      default: begin
        lx_mode = grl_pkg::MODE_IDLE;
        lex_mark(c);
      end
    endcase
    if (eos) begin
      if (lx_mode == grl_pkg::MODE_IDLE || lx_mode == grl_pkg::MODE_IDENT) begin
        if (lx_held_v) lex_ident_char(lx_held);
        lex_close_ident();
      end else if (lx_mode == grl_pkg::MODE_LIT || lx_mode == grl_pkg::MODE_LIT_ESC) begin
        lex_emit(grl_pkg::K_ERR_LIT, grl_pkg::CH_NUL);
      end else if (lx_mode == grl_pkg::MODE_BLOCK) begin
        lex_emit(grl_pkg::K_ERR_COMMENT, grl_pkg::CH_NUL);
      end
      lex_emit(grl_pkg::K_SOURCE_END, grl_pkg::CH_NUL);
      lex_reset();
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens.pop_back();
      t.last = 1'b1;
      step_tokens.push_back(t);
    end
  endfunction

  // ------------------------------------------------------------- stimulus
  function automatic void add_checked(input logic [7:0] ch, input logic eos, input int n,
                                      input logic [3:0] k0, input logic [3:0] k1,
                                      input logic [3:0] k2);
    stim_row_t r;
    r.ch    = ch;
    r.eos   = eos;
    r.typed = 1'b1;
    r.n     = 2'(n);
    r.kinds = {k2, k1, k0};
    rows.push_back(r);
  endfunction

  function automatic void add_predicted(input logic [7:0] ch, input logic eos);
    stim_row_t r;
    r.ch    = ch;
    r.eos   = eos;
    r.typed = 1'b0;
    r.n     = 2'd0;
    r.kinds = '0;
    rows.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    if (in_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Identifier character: mostly letters, sometimes any non-mark byte
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    logic       ok;
    ok = 1'b0;
    b  = 8'h00;
    while (!ok) begin
      if ($urandom_range(0, 3) != 0) b = 8'h61 + 8'($urandom_range(0, 25));
      else b = 8'($urandom_range(0, 255));
      case (b)
        grl_pkg::CH_SPACE, grl_pkg::CH_NL, grl_pkg::CH_OPEN, grl_pkg::CH_CLOSE,
        grl_pkg::CH_AMP, grl_pkg::CH_BAR, grl_pkg::CH_SEMI, grl_pkg::CH_QUOTE,
        grl_pkg::CH_MINUS, grl_pkg::CH_SLASH, grl_pkg::CH_STAR: ok = 1'b0;
        default: ok = 1'b1;
      endcase
    end
    return b;
  endfunction

  // Mostly well-formed source text with random content, some noise and
  // an occasional unterminated literal or comment at the end
  task automatic build_source();
    int         pieces;
    int         len;
    int         pick;
    logic [7:0] b;
    src_chars.delete();
    pieces = $urandom_range(1, 10);
    repeat (pieces) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        len = $urandom_range(1, 6);
        repeat (len) src_chars.push_back(plain_byte());
      end else if (pick < 44) begin
        src_chars.push_back(grl_pkg::CH_QUOTE);
        len = $urandom_range(0, 5);
        repeat (len) begin
          if ($urandom_range(0, 3) == 0) begin
            src_chars.push_back(grl_pkg::CH_BSLASH);
            case ($urandom_range(0, 2))
              0: b = grl_pkg::CH_QUOTE;
              1: b = grl_pkg::CH_BSLASH;
              default: b = 8'($urandom_range(0, 255));
            endcase
          end else begin
            b = 8'($urandom_range(0, 255));
            if (b == grl_pkg::CH_QUOTE || b == grl_pkg::CH_BSLASH) b = "x";
          end
          src_chars.push_back(b);
        end
        src_chars.push_back(grl_pkg::CH_QUOTE);
      end else if (pick < 70) begin
        case ($urandom_range(0, 5))
          0: src_chars.push_back(grl_pkg::CH_OPEN);
          1: src_chars.push_back(grl_pkg::CH_CLOSE);
          2: src_chars.push_back(grl_pkg::CH_AMP);
          3: src_chars.push_back(grl_pkg::CH_BAR);
          4: src_chars.push_back(grl_pkg::CH_SEMI);
          default: begin
            src_chars.push_back(grl_pkg::CH_MINUS);
            src_chars.push_back(grl_pkg::CH_GT);
          end
        endcase
      end else if (pick < 80) begin
        src_chars.push_back($urandom_range(0, 1) ? grl_pkg::CH_SPACE : grl_pkg::CH_NL);
      end else if (pick < 86) begin
        src_chars.push_back(grl_pkg::CH_SLASH);
        src_chars.push_back(grl_pkg::CH_SLASH);
        len = $urandom_range(0, 5);
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          if (b == grl_pkg::CH_NL) b = "x";
          src_chars.push_back(b);
        end
        src_chars.push_back(grl_pkg::CH_NL);
      end else if (pick < 92) begin
        src_chars.push_back(grl_pkg::CH_SLASH);
        src_chars.push_back(grl_pkg::CH_STAR);
        len = $urandom_range(0, 6);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0: b = grl_pkg::CH_STAR;
            1: b = grl_pkg::CH_SLASH;
            default: b = 8'($urandom_range(0, 255));
          endcase
          src_chars.push_back(b);
        end
        src_chars.push_back(grl_pkg::CH_STAR);
        src_chars.push_back(grl_pkg::CH_SLASH);
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0: b = grl_pkg::CH_MINUS;
            1: b = grl_pkg::CH_SLASH;
            2: b = grl_pkg::CH_STAR;
            default: b = 8'($urandom_range(0, 255));
          endcase
          src_chars.push_back(b);
        end
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      src_chars.push_back(grl_pkg::CH_QUOTE);
    end else if (pick < 13) begin
      src_chars.push_back(grl_pkg::CH_SLASH);
      src_chars.push_back(grl_pkg::CH_STAR);
    end else if (pick < 17) begin
      src_chars.push_back(grl_pkg::CH_SLASH);
      src_chars.push_back(grl_pkg::CH_SLASH);
    end
    if (pick < 17) begin
      len = $urandom_range(0, 3);
      repeat (len) src_chars.push_back(plain_byte());
    end
  endtask

  // Offer one character, hold it until taken, then queue its events
  task automatic send_char(input stim_row_t row);
    int     gap;
    token_t t;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= row.ch;
    in_tlast  <= row.eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lex_char(row.ch, row.eos);
    if (row.typed) begin
      for (int i = 0; i < row.n; i++) begin
        t.kind = row.kinds[i];
        t.chr  = (t.kind == grl_pkg::K_IDENT_CHAR || t.kind == grl_pkg::K_LIT_CHAR) ?
                 row.ch : grl_pkg::CH_NUL;
        t.last = (i == row.n - 1);
        tokens_due.push_back(t);
      end
    end else begin
      foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
    end
    n_items++;
    if (row.eos) n_sources++;
  endtask

  initial begin
    stim_row_t r;

    // Bracket, identifier, define mark and the top character code
    add_checked(grl_pkg::CH_OPEN,  1'b0, 1, grl_pkg::K_OPEN, K_NONE, K_NONE);
    add_checked("a",               1'b0, 1, grl_pkg::K_IDENT_CHAR, K_NONE, K_NONE);
    add_checked(grl_pkg::CH_MINUS, 1'b0, 0, K_NONE, K_NONE, K_NONE);
    add_checked(grl_pkg::CH_GT,    1'b0, 2, grl_pkg::K_IDENT_END, grl_pkg::K_DEFINE,
                K_NONE);
    add_checked(8'hFF,             1'b0, 1, grl_pkg::K_IDENT_CHAR, K_NONE, K_NONE);
    // Implicit AND before a bracket and before a literal
    add_checked(grl_pkg::CH_OPEN,  1'b0, 3, grl_pkg::K_IDENT_END, grl_pkg::K_AND,
                grl_pkg::K_OPEN);
    add_checked(grl_pkg::CH_CLOSE, 1'b0, 1, grl_pkg::K_CLOSE, K_NONE, K_NONE);
    add_checked(grl_pkg::CH_QUOTE, 1'b0, 1, grl_pkg::K_AND, K_NONE, K_NONE);
    // Doubled backslash, then an escaped quote, then a zero byte
    add_predicted(grl_pkg::CH_BSLASH, 1'b0);
    add_predicted(grl_pkg::CH_BSLASH, 1'b0);
    add_predicted(grl_pkg::CH_BSLASH, 1'b0);
    add_predicted(grl_pkg::CH_QUOTE,  1'b0);
    add_predicted(grl_pkg::CH_NUL,    1'b0);
    add_checked(grl_pkg::CH_QUOTE, 1'b0, 1, grl_pkg::K_LIT_END, K_NONE, K_NONE);
    add_checked(grl_pkg::CH_BAR,   1'b0, 1, grl_pkg::K_OR, K_NONE, K_NONE);
    // Line comment, empty block comment, stray closing mark
    add_predicted(grl_pkg::CH_SLASH, 1'b0);
    add_predicted(grl_pkg::CH_SLASH, 1'b0);
    add_predicted("q",               1'b0);
    add_predicted(grl_pkg::CH_NL,    1'b0);
    add_predicted(grl_pkg::CH_SLASH, 1'b0);
    add_predicted(grl_pkg::CH_STAR,  1'b0);
    add_predicted(grl_pkg::CH_STAR,  1'b0);
    add_predicted(grl_pkg::CH_SLASH, 1'b0);
    add_predicted(grl_pkg::CH_STAR,  1'b0);
    add_predicted(grl_pkg::CH_SLASH, 1'b0);
    add_checked(grl_pkg::CH_AMP,   1'b0, 1, grl_pkg::K_AND, K_NONE, K_NONE);
    add_checked(grl_pkg::CH_SEMI,  1'b0, 1, grl_pkg::K_DEFINE_END, K_NONE, K_NONE);
    // Held mark released at end of source, then the two error ends
    add_checked(grl_pkg::CH_MINUS, 1'b1, 3, grl_pkg::K_IDENT_CHAR, grl_pkg::K_IDENT_END,
                grl_pkg::K_SOURCE_END);
    add_checked(grl_pkg::CH_QUOTE, 1'b1, 2, grl_pkg::K_ERR_LIT, grl_pkg::K_SOURCE_END,
                K_NONE);
    add_predicted(grl_pkg::CH_SLASH, 1'b0);
    add_checked(grl_pkg::CH_STAR,  1'b1, 2, grl_pkg::K_ERR_COMMENT, grl_pkg::K_SOURCE_END,
                K_NONE);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    lex_reset();

    foreach (rows[i]) send_char(rows[i]);

    while (n_items < RANDOM_ITEMS) begin
      build_source();
      in_steady = ($urandom_range(0, 4) == 0);
      foreach (src_chars[i]) begin
        r.ch    = src_chars[i];
        r.eos   = (i == src_chars.size() - 1);
        r.typed = 1'b0;
        r.n     = 2'd0;
        r.kinds = '0;
        send_char(r);
      end
    end
    in_tvalid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d source texts; checked %0d token events.",
             n_items, n_sources, n_tokens);
    $display("Error events seen: %0d; mismatches: %0d.", n_err_tokens, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) rx_steady <= ~rx_steady;
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold    <= rx_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 99) < 25) begin
        rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin : check_tokens
    token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_tokens++;
      if (out_tuser == grl_pkg::K_ERR_LIT || out_tuser == grl_pkg::K_ERR_COMMENT) begin
        n_err_tokens++;
      end
      if (tokens_due.size() == 0) begin
        $error("token event with none expected: token_kind %0d token_char %0h",
               out_tuser, out_tdata);
        errors++;
      end else begin
        want = tokens_due.pop_front();
        if (out_tuser !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, out_tuser);
          errors++;
        end
        if (out_tdata !== want.chr) begin
          $error("token_char: expected %0h, got %0h", want.chr, out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_item: expected %0b, got %0b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d token events outstanding",
               cycles, tokens_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
